### hw/rtl/websocket_frame_deframer_defines.svh
// assertion macros for the websocket frame deframer
// used by websocket_frame_deframer.sv; expects clk and rst in scope
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// condition holds in the same cycle
`define WSD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wsd check failed");

// condition holds in the following cycle
`define WSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wsd check failed");

`endif

### hw/rtl/wsd_pkg.sv
// shared types and constants for the websocket frame deframer
// no dependencies
package wsd_pkg;

  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
  localparam logic [1:0] ST_TRUNCATED   = 2'd2;

  localparam logic [1:0] RP_NONE  = 2'd0;
  localparam logic [1:0] RP_PONG  = 2'd1;
  localparam logic [1:0] RP_CLOSE = 2'd2;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       frame_end;
    logic [3:0] frame_opcode;
    logic [1:0] status;
    logic [1:0] reply_kind;
  } result_t;

endpackage

### hw/rtl/websocket_frame_deframer.sv
// websocket frame deframer: one frame byte in, at most one result out per transfer
// a result is registered into the output register, or into the skid register while the output is stalled
// throughput: one byte per cycle while in_stall is low; a skid register absorbs one result under output stall
// in_stall rises only while the skid register is occupied
// reset (rst, synchronous) empties both output registers and waits for a header byte
`include "websocket_frame_deframer_defines.svh"

module websocket_frame_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] frame_byte,
  input  logic       buffer_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] payload_byte,
  output logic       byte_valid,
  output logic       frame_end,
  output logic [3:0] frame_opcode,
  output logic [1:0] status,
  output logic [1:0] reply_kind
);

  typedef enum logic [3:0] {
    PH_HDR0, PH_LEN, PH_EXTHI, PH_EXTLO,
    PH_KEY0, PH_KEY1, PH_KEY2, PH_KEY3,
    PH_DATA, PH_DRAIN
  } phase_t;

  phase_t               phase, phase_next;
  logic [3:0]           opcode, opcode_next;
  logic                 masked, masked_next;
  logic [15:0]          length, length_next;
  logic [3:0][7:0]      key_bytes, key_bytes_next;
  logic [15:0]          index, index_next;

  wsd_pkg::result_t     res, out_res, skid_res;
  logic                 res_fire;
  logic                 skid_valid;
  logic                 accept;
  logic                 hdr_done, hdr_cut;
  logic [7:0]           data_byte;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;

  always_comb begin
    phase_next     = phase;
    opcode_next    = opcode;
    masked_next    = masked;
    length_next    = length;
    key_bytes_next = key_bytes;
    index_next     = index;
    hdr_done       = 1'b0;
    hdr_cut        = 1'b0;
    res_fire       = 1'b0;
    res            = '0;
    data_byte      = frame_byte ^ (masked ? key_bytes[index[1:0]] : 8'h00);

    case (phase)
      PH_HDR0: begin
        opcode_next    = frame_byte[3:0];
        masked_next    = 1'b0;
        length_next    = '0;
        key_bytes_next = '0;
        index_next     = '0;
        phase_next     = PH_LEN;
        hdr_cut        = 1'b1;
      end
      PH_LEN: begin
        masked_next = frame_byte[7];
        if (frame_byte[6:0] == wsd_pkg::LEN7_EXT64) begin
          length_next = '0;
          phase_next  = buffer_last ? PH_HDR0 : PH_DRAIN;
          res_fire    = 1'b1;
          res.frame_end = 1'b1;
          res.status    = wsd_pkg::ST_UNSUPPORTED;
        end else if (frame_byte[6:0] == wsd_pkg::LEN7_EXT16) begin
          phase_next = PH_EXTHI;
          hdr_cut    = 1'b1;
        end else begin
          length_next = {9'd0, frame_byte[6:0]};
          if (frame_byte[7]) begin
            phase_next = PH_KEY0;
            hdr_cut    = 1'b1;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      PH_EXTHI: begin
        length_next = {frame_byte, 8'h00};
        phase_next  = PH_EXTLO;
        hdr_cut     = 1'b1;
      end
      PH_EXTLO: begin
        length_next = {length[15:8], frame_byte};
        if (masked) begin
          phase_next = PH_KEY0;
          hdr_cut    = 1'b1;
        end else begin
          hdr_done = 1'b1;
        end
      end
      PH_KEY0: begin
        key_bytes_next[0] = frame_byte;
        phase_next        = PH_KEY1;
        hdr_cut           = 1'b1;
      end
      PH_KEY1: begin
        key_bytes_next[1] = frame_byte;
        phase_next        = PH_KEY2;
        hdr_cut           = 1'b1;
      end
      PH_KEY2: begin
        key_bytes_next[2] = frame_byte;
        phase_next        = PH_KEY3;
        hdr_cut           = 1'b1;
      end
      PH_KEY3: begin
        key_bytes_next[3] = frame_byte;
        hdr_done          = 1'b1;
      end
      PH_DATA: begin
        index_next       = index + 16'd1;
        res_fire         = 1'b1;
        res.payload_byte = data_byte;
        res.byte_valid   = 1'b1;
        if (index_next >= length) begin
          phase_next    = buffer_last ? PH_HDR0 : PH_DRAIN;
          res.frame_end = 1'b1;
        end else if (buffer_last) begin
          phase_next    = PH_HDR0;
          res.frame_end = 1'b1;
          res.status    = wsd_pkg::ST_TRUNCATED;
        end
      end
      default: begin
        // drain: skip what is left of the buffer
        if (buffer_last) begin
          phase_next = PH_HDR0;
        end
      end
    endcase

    // buffer ran out inside the header
    if (hdr_cut && buffer_last) begin
      phase_next    = PH_HDR0;
      res_fire      = 1'b1;
      res.frame_end = 1'b1;
      res.status    = wsd_pkg::ST_TRUNCATED;
    end

    if (hdr_done) begin
      index_next = '0;
      if (length_next == 16'd0) begin
        phase_next    = buffer_last ? PH_HDR0 : PH_DRAIN;
        res_fire      = 1'b1;
        res.frame_end = 1'b1;
      end else if (buffer_last) begin
        phase_next    = PH_HDR0;
        res_fire      = 1'b1;
        res.frame_end = 1'b1;
        res.status    = wsd_pkg::ST_TRUNCATED;
      end else begin
        phase_next = PH_DATA;
      end
    end

    res.frame_opcode = opcode_next;
    res.reply_kind   = wsd_pkg::RP_NONE;
    if (res.frame_end && res.status != wsd_pkg::ST_UNSUPPORTED) begin
      if (opcode_next == wsd_pkg::OP_PING) begin
        res.reply_kind = wsd_pkg::RP_PONG;
      end else if (opcode_next == wsd_pkg::OP_CLOSE) begin
        res.reply_kind = wsd_pkg::RP_CLOSE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR0;
      opcode     <= '0;
      masked     <= 1'b0;
      length     <= '0;
      key_bytes  <= '0;
      index      <= '0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase     <= phase_next;
        opcode    <= opcode_next;
        masked    <= masked_next;
        length    <= length_next;
        key_bytes <= key_bytes_next;
        index     <= index_next;
      end
      if (out_valid && out_stall) begin
        // output held: park a new result in the skid register
        if (accept && res_fire) begin
          skid_valid <= 1'b1;
          skid_res   <= res;
        end
      end else if (skid_valid) begin
        out_valid  <= 1'b1;
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept && res_fire;
        out_res   <= res;
      end
    end
  end

  assign payload_byte = out_res.payload_byte;
  assign byte_valid   = out_res.byte_valid;
  assign frame_end    = out_res.frame_end;
  assign frame_opcode = out_res.frame_opcode;
  assign status       = out_res.status;
  assign reply_kind   = out_res.reply_kind;

  `WSD_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid)
  `WSD_ASSERT_NOW(a_empty_result_ends, out_valid && !byte_valid,
    frame_end && payload_byte == 8'h00)
  `WSD_ASSERT_NOW(a_status_on_end, out_valid && status != wsd_pkg::ST_OK, frame_end)
  `WSD_ASSERT_NOW(a_reply_on_end, out_valid && reply_kind != wsd_pkg::RP_NONE,
    frame_end && status != wsd_pkg::ST_UNSUPPORTED)
  `WSD_ASSERT_NEXT(a_skid_drains, skid_valid && !out_stall, !skid_valid)

endmodule
